@@ sv/posl_pkg.sv @@
// ----------------------------------------------------------------------------
// posl_pkg
// shared types, widths and codes for the positional ordered list
// ----------------------------------------------------------------------------
`default_nettype none

package posl_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int POS_W      = 5;
	localparam int VAL_W      = 32;
	localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	// operation codes
	localparam logic [1:0] KIND_INS_HEAD = 2'd0;
	localparam logic [1:0] KIND_INS_TAIL = 2'd1;
	localparam logic [1:0] KIND_INS_POS  = 2'd2;
	localparam logic [1:0] KIND_REM_POS  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	typedef logic signed [VAL_W-1:0] elem_t;

	typedef struct packed {
		logic [1:0]       kind;
		elem_t            value;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		elem_t            removed_value;
		logic [CNT_W-1:0] count;
		logic             empty_res;
	} rsp_t;

	// per-cell control for the current cycle
	typedef struct packed {
		logic load;       // take the inserted value
		logic from_left;  // shift toward the tail
		logic from_right; // shift toward the head
		logic tap;        // put own value on the readout chain
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/positional_ordered_list.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list
// bounded ordered list of signed 32-bit values kept in a chain of cells
// ----------------------------------------------------------------------------
// response: registered, shown on rsp in the cycle after the request is accepted
// throughput: one transaction per cycle while rsp_ready is high; every cell shifts in the same cycle
// the response register frees as it is taken, so a new request enters then
// reset: arst_n clears the element count and the response valid; cell
// contents are not reset, only slots below the count are ever read
`default_nettype none

module positional_ordered_list (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  posl_pkg::req_t      req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output posl_pkg::rsp_t      rsp
);

	localparam int D = posl_pkg::LIST_DEPTH;

	logic [posl_pkg::CNT_W-1:0] count_q;
	logic                       rsp_valid_q;
	posl_pkg::rsp_t             rsp_q;

	logic                       accept;
	logic                       is_rem;
	logic                       is_ins;
	logic                       full;
	logic                       pos_nz;
	logic [posl_pkg::CMP_W-1:0] pos_c;
	logic [posl_pkg::CMP_W-1:0] cnt_c;
	logic                       rem_ok;
	logic                       ins_ok;
	logic [posl_pkg::IDX_W-1:0] idx;
	logic [posl_pkg::POS_W-1:0] pos_m1;
	logic [1:0]                 status;
	logic [posl_pkg::CNT_W-1:0] count_nxt;

	posl_pkg::cell_ctl_t ctl   [D];
	posl_pkg::elem_t     cval  [D];
	posl_pkg::elem_t     ctap  [D];

	// response register decouples the two sides
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	// operation decode and range checks
	assign is_rem = (req.kind == posl_pkg::KIND_REM_POS);
	assign is_ins = !is_rem;
	assign full   = (count_q == posl_pkg::CNT_W'(D));
	assign pos_c  = posl_pkg::CMP_W'(req.position);
	assign cnt_c  = posl_pkg::CMP_W'(count_q);
	assign pos_nz = (req.position != '0);
	assign pos_m1 = req.position - posl_pkg::POS_W'(1);

	always_comb begin
		rem_ok = 1'b0;
		ins_ok = 1'b0;
		status = posl_pkg::ST_OK;
		idx    = '0;
		case (req.kind)
			posl_pkg::KIND_REM_POS: begin
				rem_ok = pos_nz && (pos_c <= cnt_c);
				idx    = posl_pkg::IDX_W'(pos_m1);
				if (!rem_ok) begin
					status = posl_pkg::ST_BADPOS;
				end
			end
			posl_pkg::KIND_INS_HEAD: begin
				ins_ok = !full;
				idx    = '0;
			end
			posl_pkg::KIND_INS_TAIL: begin
				ins_ok = !full;
				idx    = posl_pkg::IDX_W'(count_q);
			end
			posl_pkg::KIND_INS_POS: begin
				ins_ok = !full && pos_nz && (pos_c <= cnt_c + posl_pkg::CMP_W'(1));
				idx    = posl_pkg::IDX_W'(pos_m1);
			end
			default: begin
				ins_ok = 1'b0;
			end
		endcase
		// a full list wins over a bad position on every insert kind
		if (is_ins && full) begin
			status = posl_pkg::ST_FULL;
		end else if (is_ins && !ins_ok) begin
			status = posl_pkg::ST_BADPOS;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + posl_pkg::CNT_W'(1);
		end else if (rem_ok) begin
			count_nxt = count_q - posl_pkg::CNT_W'(1);
		end
	end

	// chain of cells: slot 0 is the head
	for (genvar gi = 0; gi < D; gi++) begin : g_cell
		logic at_idx;
		logic past_idx;

		assign at_idx   = (idx == posl_pkg::IDX_W'(gi));
		assign past_idx = (posl_pkg::IDX_W'(gi) > idx);

		// insert opens a gap at idx, remove closes the gap at idx
		assign ctl[gi].load       = accept && ins_ok && at_idx;
		assign ctl[gi].from_left  = accept && ins_ok && past_idx;
		assign ctl[gi].from_right = accept && rem_ok && (at_idx || past_idx);
		assign ctl[gi].tap        = is_rem && at_idx;

		posl_cell u_cell (
			.clk         (clk),
			.ctl         (ctl[gi]),
			.ins_value   (req.value),
			.left_value  ((gi == 0) ? req.value : cval[(gi == 0) ? 0 : gi - 1]),
			.right_value ((gi == D - 1) ? posl_pkg::elem_t'(0) :
				cval[(gi == D - 1) ? gi : gi + 1]),
			.tap_in      ((gi == D - 1) ? posl_pkg::elem_t'(0) :
				ctap[(gi == D - 1) ? gi : gi + 1]),
			.value       (cval[gi]),
			.tap_out     (ctap[gi])
		);
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// response handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status        <= status;
			rsp_q.removed_value <= rem_ok ? ctap[0] : posl_pkg::elem_t'(0);
			rsp_q.count         <= count_nxt;
			rsp_q.empty_res     <= (count_nxt == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks on the list control
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= posl_pkg::CNT_W'(D))
		else $error("element count above list depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.empty_res == (rsp.count == '0)))
		else $error("empty flag disagrees with count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_ins && full) |=> (rsp.status == posl_pkg::ST_FULL && rsp_valid))
		else $error("insert into full list not flagged");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q == rsp.count))
		else $error("response count differs from held count");

endmodule

`default_nettype wire

@@ sv/posl_cell.sv @@
// ----------------------------------------------------------------------------
// posl_cell
// one list slot: holds an element and trades it with its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module posl_cell (
	input  wire                      clk,
	input  posl_pkg::cell_ctl_t      ctl,
	input  posl_pkg::elem_t          ins_value,
	input  posl_pkg::elem_t          left_value,
	input  posl_pkg::elem_t          right_value,
	input  posl_pkg::elem_t          tap_in,
	output posl_pkg::elem_t          value,
	output posl_pkg::elem_t          tap_out
);

	posl_pkg::elem_t value_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= ins_value;
		end else if (ctl.from_left) begin
			value_q <= left_value;
		end else if (ctl.from_right) begin
			value_q <= right_value;
		end
	end

	// readout chain runs from the tail toward the head
	assign tap_out = ctl.tap ? value_q : tap_in;
	assign value   = value_q;

endmodule

`default_nettype wire

@@ verif/tb_positional_ordered_list.sv @@
// ----------------------------------------------------------------------------
// tb_positional_ordered_list
// drives list operations with bursty requests and a stalling response side,
// keeps a shadow copy of the list to predict each response and compares
// every response field against the oldest prediction
// ----------------------------------------------------------------------------

module tb_positional_ordered_list;

	import posl_pkg::*;

	// clock, reset and handshake signals
	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// shadow copy of the list contents, head first
	elem_t shadow_list[$];
	// predicted responses, oldest first
	rsp_t  pending_rsp[$];
	int    mismatches = 0;

	// sender burst bookkeeping
	int    burst_left = 0;

	// receiver stall pattern state
	int    ready_mode  = 0;
	int    ready_cycle = 0;

	positional_ordered_list dut (
		clk,
		arst_n,
		req_valid,
		req_ready,
		req,
		rsp_valid,
		rsp_ready,
		rsp
	);

	always #10 clk = ~clk;

	// watchdog: far beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: steps through randomly chosen stall modes
	// mode 0 never stalls, 1 stalls at random, 2 mostly stalls, 3 toggles
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (ready_cycle % 48 == 0)
			ready_mode <= $urandom_range(0, 3);
		ready_cycle <= ready_cycle + 1;
		case (ready_mode)
			0: begin
				rsp_ready <= 1'b1;
			end
			1: begin
				rsp_ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				rsp_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				rsp_ready <= ready_cycle[0];
			end
		endcase
	end

	// ------------------------------------------------------------------
	// response checker: every accepted response against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response transaction with nothing predicted");
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatches++;
				end
				if (rsp.removed_value !== want.removed_value) begin
					$error("removed_value: expected %0d, got %0d",
						want.removed_value, rsp.removed_value);
					mismatches++;
				end
				if (rsp.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, rsp.count);
					mismatches++;
				end
				if (rsp.empty_res !== want.empty_res) begin
					$error("empty_res: expected %0d, got %0d",
						want.empty_res, rsp.empty_res);
					mismatches++;
				end
			end
		end
	end

	// apply one operation to the shadow list and return the predicted response
	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int   n;
		int   p;
		n = shadow_list.size();
		p = r.position;
		o = '0;
		o.status = ST_OK;
		if (r.kind == KIND_REM_POS) begin
			// remove needs 1..count, empty list always fails here
			if (p >= 1 && p <= n) begin
				o.removed_value = shadow_list[p-1];
				shadow_list.delete(p-1);
			end else begin
				o.status = ST_BADPOS;
			end
		end else if (n >= LIST_DEPTH) begin
			// full wins over any position problem
			o.status = ST_FULL;
		end else if (r.kind == KIND_INS_HEAD) begin
			shadow_list.push_front(r.value);
		end else if (r.kind == KIND_INS_TAIL) begin
			shadow_list.push_back(r.value);
		end else if (p >= 1 && p <= n + 1) begin
			// count+1 appends at the tail
			shadow_list.insert(p-1, r.value);
		end else begin
			o.status = ST_BADPOS;
		end
		o.count     = CNT_W'(shadow_list.size());
		o.empty_res = (shadow_list.size() == 0);
		return o;
	endfunction

	function automatic req_t make_op(logic [1:0] k, elem_t v, int p);
		req_t r;
		r.kind     = k;
		r.value    = v;
		r.position = POS_W'(p);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// sender: one request transaction, with bursts and gaps around it
	// valid is only lowered when a real gap follows
	// ------------------------------------------------------------------
	task automatic issue_op(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// long bursts give stretches with no sender idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(req_valid && req_ready));
		// transaction taken at this edge, predict against current shadow state
		pending_rsp.push_back(list_apply(r));
	endtask

	function automatic elem_t pick_value();
		case ($urandom_range(0, 7))
			0: return elem_t'(32'h8000_0000);
			1: return elem_t'(32'h7fff_ffff);
			2: return '0;
			3: return '1;
			default: return elem_t'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// operations on an empty list
	task automatic test_empty_list();
		issue_op(make_op(KIND_REM_POS, 32'sd5, 1));  // remove from empty
		issue_op(make_op(KIND_REM_POS, 32'sd5, 0));
		issue_op(make_op(KIND_INS_POS, 32'sd9, 2));  // past count+1
		issue_op(make_op(KIND_INS_POS, 32'sd9, 0));  // position zero
	endtask

	// the list going from one element back to empty
	task automatic test_single_element();
		issue_op(make_op(KIND_INS_POS, elem_t'(32'h8000_0000), 1));
		issue_op(make_op(KIND_REM_POS, '0, 1));
	endtask

	// every operation, value extremes and position limits
	task automatic test_edge_ops();
		issue_op(make_op(KIND_INS_HEAD, elem_t'(32'h7fff_ffff), 0));
		issue_op(make_op(KIND_INS_TAIL, '1, 31));
		issue_op(make_op(KIND_INS_POS, '0, 3));                     // tail via count+1
		issue_op(make_op(KIND_INS_POS, elem_t'(32'h5555_5555), 2)); // middle
		issue_op(make_op(KIND_REM_POS, '0, 0));
		issue_op(make_op(KIND_REM_POS, '0, 5));                     // count+1
		issue_op(make_op(KIND_REM_POS, '1, 31));
		issue_op(make_op(KIND_INS_POS, elem_t'(32'haaaa_aaaa), 31));
		issue_op(make_op(KIND_REM_POS, '0, 2));                     // middle
	endtask

	// fill up, then every insert kind against a full list
	task automatic test_full_list();
		while (shadow_list.size() < LIST_DEPTH)
			issue_op(make_op(shadow_list.size() % 2 ? KIND_INS_HEAD : KIND_INS_TAIL,
				pick_value(), 0));
		issue_op(make_op(KIND_INS_HEAD, 32'sd1, 0));
		issue_op(make_op(KIND_INS_TAIL, 32'sd2, 0));
		issue_op(make_op(KIND_INS_POS, 32'sd3, 1));
		issue_op(make_op(KIND_INS_POS, 32'sd4, 0));    // full beats bad position
		issue_op(make_op(KIND_REM_POS, '0, LIST_DEPTH)); // tail element
		issue_op(make_op(KIND_REM_POS, '0, 1));          // head element
	endtask

	// ------------------------------------------------------------------
	// random traffic: segments that grow, shrink or churn the list,
	// mostly with legal positions, plus segments of raw noise
	// ------------------------------------------------------------------
	task automatic test_random_traffic(input int n_ops);
		int         seg;
		int         i;
		int         n;
		logic [1:0] k;
		int         p;
		seg = 0;
		for (i = 0; i < n_ops; i++) begin
			if (i % 40 == 0)
				seg = $urandom_range(0, 3);
			n = shadow_list.size();
			case (seg)
				0: k = ($urandom_range(0, 3) == 0) ? KIND_REM_POS : 2'($urandom_range(0, 2));
				1: k = ($urandom_range(0, 3) != 0) ? KIND_REM_POS : 2'($urandom_range(0, 2));
				default: k = 2'($urandom_range(0, 3));
			endcase
			if (seg == 3 || $urandom_range(0, 9) == 0)
				p = $urandom_range(0, 31);
			else if (k == KIND_REM_POS)
				p = (n == 0) ? $urandom_range(0, 2) : $urandom_range(1, n);
			else
				p = $urandom_range(1, n + 1);
			issue_op(make_op(k, pick_value(), p));
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int drain;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_single_element();
		test_edge_ops();
		test_full_list();
		test_random_traffic(1920);

		// last transaction was taken at this edge, drop valid before the next
		req_valid <= 1'b0;

		// wait out the outstanding responses
		drain = 0;
		while (pending_rsp.size() != 0 && drain < 10_000) begin
			@(posedge clk);
			drain++;
		end
		repeat (5) @(posedge clk);

		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("SUCCESS");
		end else begin
			if (pending_rsp.size() != 0)
				$error("%0d predicted responses never arrived", pending_rsp.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
